// ===== hdl/rmth_pkg.sv =====
`default_nettype none
package rmth_pkg;

  localparam int unsigned DW = 32;

  typedef enum logic {
    HS_LO,
    HS_HI
  } heap_sel_t;

  typedef enum logic [2:0] {
    DEC_REJ,
    DEC_PUSH_LO,
    DEC_PUSH_HI,
    DEC_MOVE_HI,
    DEC_MOVE_LO
  } dec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_PO_INIT,
    S_PO_LRD,
    S_PO_LAST,
    S_PO_CHK,
    S_PO_RC1,
    S_PO_RC2,
    S_PO_SEL,
    S_PU_INIT,
    S_PU_CHK,
    S_PU_CMP,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PO_START,
    DP_PO_RDLAST,
    DP_PO_LAST,
    DP_PO_CHK,
    DP_PO_RC1,
    DP_PO_RC2,
    DP_PO_SEL,
    DP_PU_START,
    DP_PU_CHK,
    DP_PU_CMP,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    heap_sel_t hsel;
    logic      src_top;
    logic      rej;
  } dp_cmd_t;

  typedef struct packed {
    dec_t dec;
    logic cnt_zero;
    logic c_ge_cnt;
    logic c1_lt_cnt;
    logic rc2_above;
    logic sel_above;
    logic idx_zero;
    logic pu_above;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rmth_if.sv =====
`default_nettype none
interface rmth_sample_if;
  import rmth_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmth_result_if #(parameter int unsigned CW = 11);
  import rmth_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW:0]   median_doubled;
  logic [CW-1:0]        sample_count;
  logic                 rejected;
  modport source (output valid, output median_doubled, output sample_count,
                  output rejected, input ready);
  modport sink (input valid, input median_doubled, input sample_count,
                input rejected, output ready);
endinterface
`default_nettype wire

// ===== hdl/rmth_dpath.sv =====
`default_nettype none
module rmth_dpath
  import rmth_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 512,
  parameter int unsigned AW = 9,
  parameter int unsigned SW = 10,
  parameter int unsigned CW = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic signed [DW-1:0] in_sample,
  output logic signed [DW:0]        out_median_doubled,
  output logic [CW-1:0]             out_sample_count,
  output logic                      out_rejected
);

  logic signed [DW-1:0] lo_mem [HEAP_DEPTH];
  logic signed [DW-1:0] hi_mem [HEAP_DEPTH];
  logic signed [DW-1:0] rd_lo_r, rd_hi_r, rd;
  logic signed [DW-1:0] lo_root_r, hi_root_r;
  logic signed [DW-1:0] smp_r, val_r, top_r, last_r, best_r;
  logic [AW-1:0]        idx_r, cnt_r, bidx_r;
  logic [SW-1:0]        lo_n_r, hi_n_r, n_sel;
  logic                 we_lo, we_hi, we;
  logic [AW-1:0]        wa, ra, par;
  logic signed [DW-1:0] wd;
  logic [AW:0]          c;
  logic [AW+1:0]        c1;
  logic signed [DW:0]   m2, s2;
  logic                 is_max;

  function automatic logic above(input logic signed [DW-1:0] a,
                                 input logic signed [DW-1:0] b,
                                 input logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  assign is_max = (cmd.hsel == HS_LO);
  assign rd     = is_max ? rd_lo_r : rd_hi_r;
  assign n_sel  = is_max ? lo_n_r : hi_n_r;
  assign c      = {idx_r, 1'b1};
  assign c1     = {1'b0, c} + (AW+2)'(1);
  assign par    = AW'((idx_r - AW'(1)) >> 1);
  assign s2     = {smp_r, 1'b0};

  // twice the median from the cached roots
  always_comb begin
    if (lo_n_r == '0 && hi_n_r == '0) begin
      m2 = '0;
    end else if (lo_n_r == hi_n_r) begin
      m2 = (DW+1)'(lo_root_r) + (DW+1)'(hi_root_r);
    end else if (lo_n_r < hi_n_r) begin
      m2 = {hi_root_r, 1'b0};
    end else begin
      m2 = {lo_root_r, 1'b0};
    end
  end

  always_comb begin
    if (lo_n_r == SW'(HEAP_DEPTH) && hi_n_r == SW'(HEAP_DEPTH)) begin
      stat.dec = DEC_REJ;
    end else if (lo_n_r == '0) begin
      stat.dec = DEC_PUSH_LO;
    end else if (lo_n_r == hi_n_r) begin
      stat.dec = (s2 <= m2) ? DEC_PUSH_LO : DEC_PUSH_HI;
    end else if (lo_n_r < hi_n_r) begin
      stat.dec = (s2 > m2) ? DEC_MOVE_HI : DEC_PUSH_LO;
    end else begin
      stat.dec = (s2 < m2) ? DEC_MOVE_LO : DEC_PUSH_HI;
    end
    stat.cnt_zero  = (cnt_r == '0);
    stat.c_ge_cnt  = (c >= {1'b0, cnt_r});
    stat.c1_lt_cnt = (c1 < {2'b00, cnt_r});
    stat.rc2_above = above(rd, best_r, is_max);
    stat.sel_above = above(best_r, last_r, is_max);
    stat.idx_zero  = (idx_r == '0);
    stat.pu_above  = above(val_r, rd, is_max);
  end

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = last_r;
    ra = idx_r;
    case (cmd.op)
      DP_PO_RDLAST: ra = cnt_r;
      DP_PO_CHK: begin
        if (stat.c_ge_cnt) begin
          we = 1'b1;
        end else begin
          ra = c[AW-1:0];
        end
      end
      DP_PO_RC1: ra = c1[AW-1:0];
      DP_PO_SEL: begin
        we = 1'b1;
        wd = stat.sel_above ? best_r : last_r;
      end
      DP_PU_CHK: begin
        if (stat.idx_zero) begin
          we = 1'b1;
          wd = val_r;
        end else begin
          ra = par;
        end
      end
      DP_PU_CMP: begin
        we = 1'b1;
        wd = stat.pu_above ? rd : val_r;
      end
      default: ;
    endcase
    we_lo = we && is_max;
    we_hi = we && !is_max;
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      lo_mem[wa] <= wd;
    end
    rd_lo_r <= lo_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (we_hi) begin
      hi_mem[wa] <= wd;
    end
    rd_hi_r <= hi_mem[ra];
  end

  // root copies keep the median one add away
  always_ff @(posedge clk) begin
    if (we_lo && wa == '0) begin
      lo_root_r <= wd;
    end
    if (we_hi && wa == '0) begin
      hi_root_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_n_r <= '0;
      hi_n_r <= '0;
    end else begin
      case (cmd.op)
        DP_PO_START: begin
          if (is_max) begin
            lo_n_r <= lo_n_r - SW'(1);
          end else begin
            hi_n_r <= hi_n_r - SW'(1);
          end
        end
        DP_PU_CHK, DP_PU_CMP: begin
          if ((cmd.op == DP_PU_CHK && stat.idx_zero) ||
              (cmd.op == DP_PU_CMP && !stat.pu_above)) begin
            if (is_max) begin
              lo_n_r <= lo_n_r + SW'(1);
            end else begin
              hi_n_r <= hi_n_r + SW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: smp_r <= in_sample;
      DP_PO_START: begin
        top_r <= is_max ? lo_root_r : hi_root_r;
        cnt_r <= AW'(n_sel - SW'(1));
        idx_r <= '0;
      end
      DP_PO_LAST: last_r <= rd;
      DP_PO_RC1: begin
        best_r <= rd;
        bidx_r <= c[AW-1:0];
      end
      DP_PO_RC2: begin
        if (stat.rc2_above) begin
          best_r <= rd;
          bidx_r <= c1[AW-1:0];
        end
      end
      DP_PO_SEL: begin
        if (stat.sel_above) begin
          idx_r <= bidx_r;
        end
      end
      DP_PU_START: begin
        idx_r <= n_sel[AW-1:0];
        val_r <= cmd.src_top ? top_r : smp_r;
      end
      DP_PU_CMP: begin
        if (stat.pu_above) begin
          idx_r <= par;
        end
      end
      DP_OUT: begin
        out_median_doubled <= m2;
        out_sample_count   <= CW'(lo_n_r) + CW'(hi_n_r);
        out_rejected       <= cmd.rej;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/rmth_ctrl.sv =====
`default_nettype none
module rmth_ctrl
  import rmth_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t    state_r, state_nxt;
  heap_sel_t hsel_r, hsel_nxt;
  logic      src_r, src_nxt, more_r, more_nxt, rej_r, rej_nxt;
  logic      out_valid_r, out_valid_nxt, fin_fire;

  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    hsel_nxt  = hsel_r;
    src_nxt   = src_r;
    more_nxt  = more_r;
    rej_nxt   = rej_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        rej_nxt  = 1'b0;
        src_nxt  = 1'b0;
        more_nxt = 1'b0;
        unique case (stat.dec)
          DEC_REJ: begin
            rej_nxt   = 1'b1;
            state_nxt = S_FIN;
          end
          DEC_PUSH_LO: begin
            hsel_nxt  = HS_LO;
            state_nxt = S_PU_INIT;
          end
          DEC_PUSH_HI: begin
            hsel_nxt  = HS_HI;
            state_nxt = S_PU_INIT;
          end
          DEC_MOVE_HI: begin
            hsel_nxt  = HS_HI;
            more_nxt  = 1'b1;
            state_nxt = S_PO_INIT;
          end
          DEC_MOVE_LO: begin
            hsel_nxt  = HS_LO;
            more_nxt  = 1'b1;
            state_nxt = S_PO_INIT;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_PO_INIT: state_nxt = S_PO_LRD;
      S_PO_LRD: begin
        if (stat.cnt_zero) begin
          hsel_nxt  = (hsel_r == HS_LO) ? HS_HI : HS_LO;
          src_nxt   = 1'b1;
          state_nxt = S_PU_INIT;
        end else begin
          state_nxt = S_PO_LAST;
        end
      end
      S_PO_LAST: state_nxt = S_PO_CHK;
      S_PO_CHK: begin
        if (stat.c_ge_cnt) begin
          hsel_nxt  = (hsel_r == HS_LO) ? HS_HI : HS_LO;
          src_nxt   = 1'b1;
          state_nxt = S_PU_INIT;
        end else begin
          state_nxt = S_PO_RC1;
        end
      end
      S_PO_RC1: state_nxt = stat.c1_lt_cnt ? S_PO_RC2 : S_PO_SEL;
      S_PO_RC2: state_nxt = S_PO_SEL;
      S_PO_SEL: begin
        if (stat.sel_above) begin
          state_nxt = S_PO_CHK;
        end else begin
          hsel_nxt  = (hsel_r == HS_LO) ? HS_HI : HS_LO;
          src_nxt   = 1'b1;
          state_nxt = S_PU_INIT;
        end
      end
      S_PU_INIT: state_nxt = S_PU_CHK;
      S_PU_CHK, S_PU_CMP: begin
        if ((state_r == S_PU_CHK && stat.idx_zero) ||
            (state_r == S_PU_CMP && !stat.pu_above)) begin
          if (more_r) begin
            more_nxt  = 1'b0;
            hsel_nxt  = (hsel_r == HS_LO) ? HS_HI : HS_LO;
            src_nxt   = 1'b0;
            state_nxt = S_PU_INIT;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (state_r == S_PU_CHK) begin
          state_nxt = S_PU_CMP;
        end else begin
          state_nxt = S_PU_CHK;
        end
      end
      S_FIN: if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || fin_fire;
  end

  always_comb begin
    cmd.hsel    = hsel_r;
    cmd.src_top = src_r;
    cmd.rej     = rej_r;
    cmd.op      = DP_NOP;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_PO_INIT: cmd.op = DP_PO_START;
      S_PO_LRD:  cmd.op = stat.cnt_zero ? DP_NOP : DP_PO_RDLAST;
      S_PO_LAST: cmd.op = DP_PO_LAST;
      S_PO_CHK:  cmd.op = DP_PO_CHK;
      S_PO_RC1:  cmd.op = DP_PO_RC1;
      S_PO_RC2:  cmd.op = DP_PO_RC2;
      S_PO_SEL:  cmd.op = DP_PO_SEL;
      S_PU_INIT: cmd.op = DP_PU_START;
      S_PU_CHK:  cmd.op = DP_PU_CHK;
      S_PU_CMP:  cmd.op = DP_PU_CMP;
      S_FIN:     cmd.op = fin_fire ? DP_OUT : DP_NOP;
      default:   cmd.op = DP_NOP;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hsel_r      <= HS_LO;
      src_r       <= 1'b0;
      more_r      <= 1'b0;
      rej_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hsel_r      <= hsel_nxt;
      src_r       <= src_nxt;
      more_r      <= more_nxt;
      rej_r       <= rej_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/running_median_two_heaps_core.sv =====
// flow: one sample at a time; a push sifts up, a pop sifts down, and a root move
//   pops one root then pushes twice; the next sample is accepted only once the last
//   result sits in the output register, and the sifts share the single read port
//   of each heap memory
// reset: rst_n low clears both heap sizes and the handshake state; heap memories
//   keep no reset and are only read below the current sizes
`default_nettype none
module running_median_two_heaps_core
  import rmth_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rmth_sample_if.sink in_ch,
  rmth_result_if.source out_ch
);

  // address, size and count widths follow the heap depth
  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned SW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CW = $clog2(2 * HEAP_DEPTH + 1);

  // commands from the sequencer, status back from the heap datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides the route of each sample, walks pop and push sifts
  rmth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // two heap memories, cached roots, sizes and the output beat register
  rmth_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .AW         (AW),
    .SW         (SW),
    .CW         (CW)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample          (in_ch.sample),
    .out_median_doubled (out_ch.median_doubled),
    .out_sample_count   (out_ch.sample_count),
    .out_rejected       (out_ch.rejected)
  );

endmodule
`default_nettype wire

// ===== bench/rmth_median_checker.sv =====
`timescale 1ns / 1ps
module rmth_median_checker
  import rmth_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rmth_sample_if    in_ch,
  rmth_result_if    out_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic signed [DW:0] median_doubled;
    logic [10:0]        sample_count;
    logic               rejected;
  } median_beat_t;

  // all held samples in ascending order
  longint       held_sorted[$];
  median_beat_t median_expected[$];

  function automatic logic signed [DW:0] doubled_median();
    int n;
    n = held_sorted.size();
    if (n == 0) return '0;
    if (n % 2 == 1) return (DW+1)'(2 * held_sorted[n / 2]);
    return (DW+1)'(held_sorted[n / 2 - 1] + held_sorted[n / 2]);
  endfunction

  task automatic absorb_sample(input logic signed [DW-1:0] s);
    median_beat_t b;
    int pos;
    b.rejected = 1'b0;
    // store full: drop the sample, state stays
    if (held_sorted.size() >= 2 * HEAP_DEPTH) begin
      b.rejected = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_sorted.size() && held_sorted[pos] <= longint'(s)) pos++;
      held_sorted.insert(pos, longint'(s));
    end
    b.median_doubled = doubled_median();
    b.sample_count   = 11'(held_sorted.size());
    median_expected.push_back(b);
  endtask

  always @(posedge clk) begin
    median_beat_t want;
    if (!rst_n) begin
      held_sorted.delete();
      median_expected.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_sample(in_ch.sample);
      if (out_ch.valid && out_ch.ready) begin
        if (median_expected.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: median_doubled=%0d",
                                        out_ch.median_doubled);
          fail_count <= fail_count + 1;
        end else begin
          want = median_expected.pop_front();
          if (want.median_doubled !== out_ch.median_doubled ||
              want.sample_count !== out_ch.sample_count ||
              want.rejected !== out_ch.rejected) begin
            if (fail_count < 10)
              $display("mismatch: exp median2=%0d cnt=%0d rej=%0b got median2=%0d cnt=%0d rej=%0b",
                       want.median_doubled, want.sample_count, want.rejected,
                       out_ch.median_doubled, out_ch.sample_count, out_ch.rejected);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= median_expected.size();
    end
  end

endmodule

// ===== bench/tb_running_median_two_heaps_core.sv =====
`timescale 1ns / 1ps
module tb_running_median_two_heaps_core;
  import rmth_pkg::*;

  localparam int unsigned HEAP_DEPTH = 512;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;

  rmth_sample_if in_ch ();
  rmth_result_if out_ch ();

  running_median_two_heaps_core #(.HEAP_DEPTH(HEAP_DEPTH)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rmth_median_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // offers one sample beat and holds it until the block takes it;
  // a random gap may come first, valid is only lowered during a gap
  task automatic push_sample(input logic signed [DW-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // draws a sample: mostly small ranges so ties and duplicates are common,
  // sometimes full-range or extreme values
  function automatic logic signed [DW-1:0] draw_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(7)) - 32'sd4;
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                   : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($urandom_range(2000)) - 32'sd1000;
    endcase
  endfunction

  // drop valid and wait until every expected beat has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    tx_idle_pct  = 10;
    rx_idle_pct  = 63;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first sample, extremes, ties on both balance states
    push_sample(32'sd0);          // first sample goes low without a compare
    push_sample(32'sd0);          // tie with one heap larger
    push_sample(32'sd0);          // tie with equal sizes
    push_sample(32'h8000_0000);   // most negative, moves a root across
    push_sample(32'h7fff_ffff);   // most positive
    push_sample(32'h7fff_ffff);
    push_sample(32'h7fff_ffff);   // third most positive; the median stays at zero
    push_sample(32'h8000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'h8000_0000);
    push_sample(32'sd5);
    push_sample(-32'sd5);
    push_sample(32'sd1);
    push_sample(-32'sd1);
    push_sample(32'h5555_5555);
    push_sample(32'haaaa_aaaa);
    push_sample(32'sd3);
    push_sample(32'sd3);
    push_sample(32'sd2);
    push_sample(32'sd4);
    // pause until every result is back
    drain();

    // three idle profiles; the store fills up and then rejects
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 10; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (600) push_sample(draw_sample());
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rmth_pkg.sv
hdl/rmth_if.sv
hdl/rmth_dpath.sv
hdl/rmth_ctrl.sv
hdl/running_median_two_heaps_core.sv
bench/rmth_median_checker.sv
bench/tb_running_median_two_heaps_core.sv
